>>> rtl/core/gwn_pkg.sv
// Package for the group weight neutraliser: widths, codes, item and handshake types
// and the saturating accumulator and magnitude helpers. Depends on nothing.
package gwn_pkg;

    localparam int NUM_GROUPS_DEF = 256;
    localparam int GID_W          = 8;
    localparam int DATA_W         = 32;
    localparam int SUM_W          = 48;
    localparam int S_TDATA_W      = 80;
    localparam int S_TUSER_W      = 3;
    localparam int M_TDATA_W      = 32;
    localparam int PROD_W         = 128;
    localparam int MULA_W         = 96;
    localparam int QUO_W          = 32;

    typedef enum logic
    {
        OP_ACCUMULATE = 1'b0,
        OP_APPLY      = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                      op;
        logic                     in_range;
        logic [GID_W-1:0]         group;
        logic signed [DATA_W-1:0] member_weight;
        logic                     member_finite;
        logic signed [DATA_W-1:0] signal_value;
        logic                     signal_finite;
        logic                     last;
    } item_t;

    typedef struct packed
    {
        logic                     start;
        logic signed [SUM_W-1:0]  member_group;
        logic signed [SUM_W-1:0]  signal_group;
        logic signed [SUM_W-1:0]  member_total;
        logic signed [SUM_W-1:0]  signal_total;
        logic signed [DATA_W-1:0] signal_value;
    } ratio_req_t;

    typedef struct packed
    {
        logic              done;
        logic [DATA_W-1:0] value;
    } ratio_rsp_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_READ,
        BK_DATA,
        BK_CALC,
        BK_OUT
    } back_state_t;

    typedef enum logic [2:0]
    {
        RT_IDLE,
        RT_MUL1,
        RT_MUL2,
        RT_MUL3,
        RT_CHECK,
        RT_DIV,
        RT_DONE
    } ratio_state_t;

    function automatic logic signed [SUM_W-1:0] sat_add48(input logic signed [SUM_W-1:0] a,
                                                          input logic signed [DATA_W-1:0] b);
        logic signed [SUM_W:0] s;
        begin
            s = {a[SUM_W-1], a} + {{(SUM_W-DATA_W+1){b[DATA_W-1]}}, b};
            if (s[SUM_W] != s[SUM_W-1])
            begin
                sat_add48 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                sat_add48 = s[SUM_W-1:0];
            end
        end
    endfunction

    function automatic logic [SUM_W-1:0] mag48(input logic signed [SUM_W-1:0] x);
        begin
            mag48 = x[SUM_W-1] ? SUM_W'(-x) : x;
        end
    endfunction

endpackage

>>> rtl/core/gwn_front.sv
// Front end: unpacks and classifies incoming requests and holds them in a two-entry queue.
// Depends on gwn_pkg.
module gwn_front #(
    parameter int NUM_GROUPS = gwn_pkg::NUM_GROUPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gwn_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [gwn_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           s_tlast,
    output logic                           q_valid,
    output gwn_pkg::item_t                 q_item,
    input  logic                           q_pop
);

    gwn_pkg::item_t item_in;
    gwn_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    logic [8:0]     gid;

    assign gid = s_tdata[8:0];

    always_comb
    begin
        item_in.op            = gwn_pkg::op_t'(s_tuser[0]);
        item_in.in_range      = !gid[8] && (32'(gid[7:0]) < NUM_GROUPS);
        item_in.group         = gid[7:0];
        item_in.member_weight = s_tdata[40:9];
        item_in.member_finite = s_tuser[1];
        item_in.signal_value  = s_tdata[72:41];
        item_in.signal_finite = s_tuser[2];
        item_in.last          = s_tlast;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> rtl/core/gwn_ratio.sv
// Sequential ratio unit: byte-serial multiplier and restoring divider that form the
// rounded, saturated rescaled signal. Depends on gwn_pkg.
module gwn_ratio (
    input  logic                clk,
    input  logic                rst_n,
    input  gwn_pkg::ratio_req_t req,
    output gwn_pkg::ratio_rsp_t rsp
);

    gwn_pkg::ratio_state_t state_reg, state_next;
    logic [gwn_pkg::MULA_W-1:0]  a_reg, a_next;
    logic [gwn_pkg::SUM_W-1:0]   b_reg, b_next;
    logic [gwn_pkg::PROD_W-1:0]  acc_reg, acc_next;
    logic [gwn_pkg::PROD_W-1:0]  num_reg, num_next;
    logic [gwn_pkg::PROD_W-1:0]  den_reg, den_next;
    logic [gwn_pkg::QUO_W-1:0]   q_reg, q_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic                        sat_reg, sat_next;
    logic [gwn_pkg::SUM_W-1:0]   mt_reg, mt_next;
    logic [gwn_pkg::SUM_W-1:0]   sg_reg, sg_next;
    logic [gwn_pkg::DATA_W-1:0]  sv_reg, sv_next;
    logic [gwn_pkg::MULA_W+7:0]  prod;
    logic [gwn_pkg::PROD_W-1:0]  acc_step;
    logic [gwn_pkg::QUO_W:0]     lim;
    logic [gwn_pkg::QUO_W:0]     qm;

    assign prod     = a_reg * b_reg[47:40];
    assign acc_step = {acc_reg[119:0], 8'b0} + gwn_pkg::PROD_W'(prod);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gwn_pkg::RT_IDLE:
            begin
                if (req.start)
                begin
                    state_next = gwn_pkg::RT_MUL1;
                end
            end
            gwn_pkg::RT_MUL1:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = gwn_pkg::RT_MUL2;
                end
            end
            gwn_pkg::RT_MUL2:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = gwn_pkg::RT_MUL3;
                end
            end
            gwn_pkg::RT_MUL3:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = gwn_pkg::RT_CHECK;
                end
            end
            gwn_pkg::RT_CHECK:
            begin
                state_next = sat_next ? gwn_pkg::RT_DONE : gwn_pkg::RT_DIV;
            end
            gwn_pkg::RT_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = gwn_pkg::RT_DONE;
                end
            end
            gwn_pkg::RT_DONE:
            begin
                state_next = gwn_pkg::RT_IDLE;
            end
            default:
            begin
                state_next = gwn_pkg::RT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        num_next = num_reg;
        den_next = den_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        sat_next = sat_reg;
        mt_next  = mt_reg;
        sg_next  = sg_reg;
        sv_next  = sv_reg;
        case (state_reg)
            gwn_pkg::RT_IDLE:
            begin
                a_next   = gwn_pkg::MULA_W'(gwn_pkg::mag48(req.member_group));
                b_next   = gwn_pkg::mag48(req.signal_total);
                acc_next = '0;
                cnt_next = 5'd5;
                neg_next = req.member_group[47] ^ req.signal_group[47] ^ req.member_total[47]
                           ^ req.signal_total[47] ^ req.signal_value[31];
                sat_next = 1'b0;
                q_next   = '0;
                mt_next  = gwn_pkg::mag48(req.member_total);
                sg_next  = gwn_pkg::mag48(req.signal_group);
                sv_next  = req.signal_value[31] ? 32'(-req.signal_value) : req.signal_value;
            end
            gwn_pkg::RT_MUL1:
            begin
                acc_next = acc_step;
                b_next   = {b_reg[39:0], 8'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    a_next   = acc_step[gwn_pkg::MULA_W-1:0];
                    b_next   = {sv_reg, 16'b0};
                    acc_next = '0;
                    cnt_next = 5'd3;
                end
            end
            gwn_pkg::RT_MUL2:
            begin
                acc_next = acc_step;
                b_next   = {b_reg[39:0], 8'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    num_next = acc_step;
                    a_next   = gwn_pkg::MULA_W'(mt_reg);
                    b_next   = sg_reg;
                    acc_next = '0;
                    cnt_next = 5'd5;
                end
            end
            gwn_pkg::RT_MUL3:
            begin
                acc_next = acc_step;
                b_next   = {b_reg[39:0], 8'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    num_next = {num_reg[126:0], 1'b0} + acc_step;
                    den_next = {acc_step[126:0], 1'b0};
                end
            end
            gwn_pkg::RT_CHECK:
            begin
                sat_next = (num_reg >= {den_reg[95:0], 32'b0});
                den_next = {den_reg[96:0], 31'b0};
                cnt_next = 5'd31;
            end
            gwn_pkg::RT_DIV:
            begin
                if (num_reg >= den_reg)
                begin
                    num_next = num_reg - den_reg;
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    q_next   = {q_reg[30:0], 1'b0};
                end
                den_next = {1'b0, den_reg[127:1]};
                cnt_next = cnt_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        lim = neg_reg ? 33'h080000000 : 33'h07FFFFFFF;
        qm  = (sat_reg || ({1'b0, q_reg} > lim)) ? lim : {1'b0, q_reg};
        rsp.done  = (state_reg == gwn_pkg::RT_DONE);
        rsp.value = neg_reg ? 32'(-qm) : qm[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gwn_pkg::RT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        num_reg <= num_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
        mt_reg  <= mt_next;
        sg_reg  <= sg_next;
        sv_reg  <= sv_next;
    end

endmodule

>>> rtl/core/gwn_back.sv
// Back end: per-group sum memories, totals, the item sequencer and the output register.
// Depends on gwn_pkg and gwn_ratio.
module gwn_back #(
    parameter int NUM_GROUPS = gwn_pkg::NUM_GROUPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  gwn_pkg::item_t                 q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gwn_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int IDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    gwn_pkg::back_state_t state_reg, state_next;
    gwn_pkg::item_t       cur_reg, cur_next;
    gwn_pkg::ratio_req_t  rreq;
    gwn_pkg::ratio_rsp_t  rrsp;

    logic signed [gwn_pkg::SUM_W-1:0] mem_m [NUM_GROUPS];
    logic signed [gwn_pkg::SUM_W-1:0] mem_s [NUM_GROUPS];
    logic signed [gwn_pkg::SUM_W-1:0] rd_m_reg, rd_s_reg;
    logic [NUM_GROUPS-1:0]            mseen_reg, mseen_next;
    logic [NUM_GROUPS-1:0]            sseen_reg, sseen_next;
    logic signed [gwn_pkg::SUM_W-1:0] mt_reg, mt_next;
    logic signed [gwn_pkg::SUM_W-1:0] st_reg, st_next;
    logic [gwn_pkg::DATA_W-1:0]       res_value_reg, res_value_next;
    logic                             res_valid_reg, res_valid_next;
    logic                             obuf_valid_reg, obuf_valid_next;
    logic [gwn_pkg::DATA_W-1:0]       obuf_value_reg, obuf_value_next;
    logic                             obuf_ok_reg, obuf_ok_next;
    logic                             obuf_last_reg, obuf_last_next;
    logic [IDX_W-1:0]                 idx;
    logic signed [gwn_pkg::SUM_W-1:0] mg, sg, mg_new, sg_new;
    logic                             mem_we;
    logic                             out_free;

    assign idx      = IDX_W'(cur_reg.group);
    assign mg       = mseen_reg[idx] ? rd_m_reg : '0;
    assign sg       = sseen_reg[idx] ? rd_s_reg : '0;
    assign mg_new   = cur_reg.member_finite ? gwn_pkg::sat_add48(mg, cur_reg.member_weight) : mg;
    assign sg_new   = cur_reg.signal_finite ? gwn_pkg::sat_add48(sg, cur_reg.signal_value) : sg;
    assign out_free = !obuf_valid_reg || m_tready;

    assign m_tvalid = obuf_valid_reg;
    assign m_tdata  = obuf_value_reg;
    assign m_tuser  = obuf_ok_reg;
    assign m_tlast  = obuf_last_reg;

    gwn_ratio u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rreq),
        .rsp   (rrsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gwn_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == gwn_pkg::OP_ACCUMULATE)
                    begin
                        state_next = q_item.in_range ? gwn_pkg::BK_READ : gwn_pkg::BK_IDLE;
                    end
                    else
                    begin
                        state_next = (q_item.in_range && q_item.signal_finite) ?
                                     gwn_pkg::BK_READ : gwn_pkg::BK_OUT;
                    end
                end
            end
            gwn_pkg::BK_READ:
            begin
                state_next = gwn_pkg::BK_DATA;
            end
            gwn_pkg::BK_DATA:
            begin
                if (cur_reg.op == gwn_pkg::OP_ACCUMULATE)
                begin
                    state_next = gwn_pkg::BK_IDLE;
                end
                else if (!mseen_reg[idx] || mt_reg == '0 || sg == '0)
                begin
                    state_next = gwn_pkg::BK_OUT;
                end
                else
                begin
                    state_next = gwn_pkg::BK_CALC;
                end
            end
            gwn_pkg::BK_CALC:
            begin
                if (rrsp.done)
                begin
                    state_next = gwn_pkg::BK_OUT;
                end
            end
            gwn_pkg::BK_OUT:
            begin
                if (out_free)
                begin
                    state_next = gwn_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = gwn_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next        = cur_reg;
        mseen_next      = mseen_reg;
        sseen_next      = sseen_reg;
        mt_next         = mt_reg;
        st_next         = st_reg;
        res_value_next  = res_value_reg;
        res_valid_next  = res_valid_reg;
        obuf_valid_next = obuf_valid_reg && !m_tready;
        obuf_value_next = obuf_value_reg;
        obuf_ok_next    = obuf_ok_reg;
        obuf_last_next  = obuf_last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        rreq.start        = 1'b0;
        rreq.member_group = mg;
        rreq.signal_group = sg;
        rreq.member_total = mt_reg;
        rreq.signal_total = st_reg;
        rreq.signal_value = cur_reg.signal_value;
        case (state_reg)
            gwn_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    cur_next       = q_item;
                    res_value_next = '0;
                    res_valid_next = 1'b0;
                end
            end
            gwn_pkg::BK_DATA:
            begin
                if (cur_reg.op == gwn_pkg::OP_ACCUMULATE)
                begin
                    mem_we = 1'b1;
                    if (cur_reg.member_finite)
                    begin
                        mseen_next[idx] = 1'b1;
                        mt_next         = gwn_pkg::sat_add48(mt_reg, cur_reg.member_weight);
                    end
                    if (cur_reg.signal_finite)
                    begin
                        sseen_next[idx] = 1'b1;
                        st_next         = gwn_pkg::sat_add48(st_reg, cur_reg.signal_value);
                    end
                end
                else if (!mseen_reg[idx])
                begin
                    res_valid_next = 1'b1;
                end
                else if (mt_reg != '0 && sg != '0)
                begin
                    rreq.start = 1'b1;
                end
            end
            gwn_pkg::BK_CALC:
            begin
                if (rrsp.done)
                begin
                    res_value_next = rrsp.value;
                    res_valid_next = 1'b1;
                end
            end
            gwn_pkg::BK_OUT:
            begin
                if (out_free)
                begin
                    obuf_valid_next = 1'b1;
                    obuf_value_next = res_value_reg;
                    obuf_ok_next    = res_valid_reg;
                    obuf_last_next  = cur_reg.last;
                    if (cur_reg.last)
                    begin
                        mseen_next = '0;
                        sseen_next = '0;
                        mt_next    = '0;
                        st_next    = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gwn_pkg::BK_IDLE;
            mseen_reg      <= '0;
            sseen_reg      <= '0;
            mt_reg         <= '0;
            st_reg         <= '0;
            obuf_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mseen_reg      <= mseen_next;
            sseen_reg      <= sseen_next;
            mt_reg         <= mt_next;
            st_reg         <= st_next;
            obuf_valid_reg <= obuf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        res_value_reg  <= res_value_next;
        res_valid_reg  <= res_valid_next;
        obuf_value_reg <= obuf_value_next;
        obuf_ok_reg    <= obuf_ok_next;
        obuf_last_reg  <= obuf_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_m[idx] <= mg_new;
            mem_s[idx] <= sg_new;
        end
        rd_m_reg <= mem_m[idx];
        rd_s_reg <= mem_s[idx];
    end

endmodule

>>> rtl/core/group_weight_neutralizer_core.sv
// Group weight neutraliser, top level: front queue, back sequencer and ratio unit.
// Depends on gwn_pkg, gwn_front and gwn_back.
// An accumulate request holds the back end through its read and data states; an apply request
// that uses the ratio unit passes its multiplier and, unless it saturates, its divider.
// The two-entry queue accepts requests while the back end is busy, until both entries are full.
// Reset clears the group flags and totals at once, so no clearing pass is needed.
module group_weight_neutralizer_core #(
    parameter int NUM_GROUPS = gwn_pkg::NUM_GROUPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // group[8:0], member_weight[40:9], signal_value[72:41], zero fill
    input  logic [gwn_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // op[0], member_finite[1], signal_finite[2]
    input  logic [gwn_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_value[31:0]
    output logic [gwn_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // out_valid[0]
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    logic           q_valid;
    logic           q_pop;
    gwn_pkg::item_t q_item;

    gwn_front #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .s_tlast  (s_axis_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    gwn_back #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid result carries a nonzero value");

endmodule

>>> dv/tb_group_weight_neutralizer_core.sv
// Self-checking testbench for group_weight_neutralizer_core: directed table, then random
// cross-sections under varying idling and output stalls, checked against an in-bench predictor.
// Depends on gwn_pkg and the RTL of group_weight_neutralizer_core.
module tb_group_weight_neutralizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  GROUPS      = 256;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam longint SUM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO   = -SUM_HI - 1;

    typedef struct
    {
        gwn_pkg::op_t       op;
        logic signed [8:0]  gid;
        logic signed [31:0] mw;
        logic               mf;
        logic signed [31:0] sv;
        logic               sf;
        logic               last;
    } request_t;

    typedef struct
    {
        logic [31:0] value;
        logic        ok;
        logic        last;
    } rescaled_t;

    typedef struct
    {
        request_t  req;
        logic      typed;
        rescaled_t res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    longint    member_sum [GROUPS];
    longint    signal_sum [GROUPS];
    bit        member_seen [GROUPS];
    bit        signal_seen [GROUPS];
    longint    member_total;
    longint    signal_total;

    rescaled_t pending_results[$];
    row_t      directed_rows[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    bit        pressure = 1'b0;
    int        hold_count = 0;

    always #2 clk = ~clk;

    group_weight_neutralizer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic longint sum48(input longint a, input longint b);
        longint s;
        begin
            s = a + b;
            if (s > SUM_HI)
            begin
                s = SUM_HI;
            end
            else if (s < SUM_LO)
            begin
                s = SUM_LO;
            end
            return s;
        end
    endfunction

    function automatic logic [127:0] abs128(input longint v);
        begin
            return (v < 0) ? 128'(-v) : 128'(v);
        end
    endfunction

    function automatic void clear_sums();
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                member_sum[g] = 0;
                signal_sum[g] = 0;
                member_seen[g] = 1'b0;
                signal_seen[g] = 1'b0;
            end
            member_total = 0;
            signal_total = 0;
        end
    endfunction

    // Updates the sums and returns 1 with the rescaled signal for an apply request.
    function automatic bit neutralize_item(input request_t r, output rescaled_t res);
        bit           hit;
        int           g;
        longint       mg;
        longint       sg;
        bit           neg;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] lim;
        logic [127:0] qm;
        begin
            hit = (r.gid >= 0);
            g = hit ? int'(r.gid) : 0;
            res.value = '0;
            res.ok = 1'b0;
            res.last = r.last;
            if (r.op == gwn_pkg::OP_ACCUMULATE)
            begin
                if (hit && r.mf)
                begin
                    member_sum[g] = sum48(member_sum[g], longint'(r.mw));
                    member_seen[g] = 1'b1;
                    member_total = sum48(member_total, longint'(r.mw));
                end
                if (hit && r.sf)
                begin
                    signal_sum[g] = sum48(signal_sum[g], longint'(r.sv));
                    signal_seen[g] = 1'b1;
                    signal_total = sum48(signal_total, longint'(r.sv));
                end
                return 1'b0;
            end
            if (hit && r.sf)
            begin
                if (!member_seen[g])
                begin
                    res.ok = 1'b1;
                end
                else
                begin
                    mg = member_sum[g];
                    sg = signal_seen[g] ? signal_sum[g] : 0;
                    if (member_total != 0 && sg != 0)
                    begin
                        neg = (r.sv < 0) ^ (mg < 0) ^ (signal_total < 0)
                            ^ (member_total < 0) ^ (sg < 0);
                        num = abs128(mg) * abs128(signal_total) * abs128(longint'(r.sv));
                        den = abs128(member_total) * abs128(sg);
                        quo = (2 * num + den) / (2 * den);
                        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                        qm = (quo > lim) ? lim : quo;
                        res.value = neg ? 32'(-qm) : 32'(qm);
                        res.ok = 1'b1;
                    end
                end
            end
            if (r.last)
            begin
                clear_sums();
            end
            return 1'b1;
        end
    endfunction

    task automatic send_request(input request_t r, input bit typed, input rescaled_t typed_res);
        rescaled_t res;
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {7'b0, r.sv, r.mw, r.gid};
            s_axis_tuser <= {r.sf, r.mf, r.op};
            s_axis_tlast <= r.last;
            @(posedge clk);
            while (!s_axis_tready)
            begin
                @(posedge clk);
            end
            if (neutralize_item(r, res))
            begin
                pending_results.push_back(typed ? typed_res : res);
            end
        end
    endtask

    function automatic logic signed [31:0] rand_value();
        begin
            case ($urandom_range(0, 3))
                0: return $urandom;
                1: return 32'sd65536 * $signed(32'($urandom_range(0, 40))) - 32'sd1310720;
                2: return $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
                default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            endcase
        end
    endfunction

    function automatic logic signed [8:0] rand_group();
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                return 9'($urandom_range(0, 7));
            end
            return 9'($urandom_range(0, 511));
        end
    endfunction

    function automatic request_t rand_request(input gwn_pkg::op_t op, input logic last);
        request_t r;
        begin
            r.op = op;
            r.gid = rand_group();
            r.mw = rand_value();
            r.mf = ($urandom_range(0, 9) != 0);
            r.sv = rand_value();
            r.sf = ($urandom_range(0, 9) != 0);
            r.last = last;
            return r;
        end
    endfunction

    task automatic add_row(input gwn_pkg::op_t op, input int gid, input logic [31:0] mw,
                           input logic mf, input logic [31:0] sv, input logic sf,
                           input logic last, input logic typed, input logic [31:0] value,
                           input logic ok);
        row_t row;
        begin
            row.req = '{op, 9'(gid), mw, mf, sv, sf, last};
            row.typed = typed;
            row.res = '{value, ok, last};
            directed_rows.push_back(row);
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("group_weight_neutralizer_core test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (pressure && hold_count < 400)
        begin
            hold_count <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rescaled_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: value %h valid %b last %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_axis_tdata !== e.value || m_axis_tuser !== e.ok
                    || m_axis_tlast !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected %h/%b/%b, actual %h/%b/%b",
                                 e.value, e.ok, e.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
        end
    end

    initial
    begin
        rescaled_t none;
        request_t  r;
        int        sent;
        int        n;
        none = '{32'h0, 1'b0, 1'b0};
        clear_sums();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(gwn_pkg::OP_APPLY, -1, 32'h0, 1'b0, 32'h0001_0000, 1'b1, 1'b0,
                1'b1, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 5, 32'h0, 1'b0, 32'h0001_0000, 1'b0, 1'b0,
                1'b1, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 5, 32'h0, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0,
                1'b1, 32'h0, 1'b1);
        add_row(gwn_pkg::OP_ACCUMULATE, 3, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_ACCUMULATE, 4, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_ACCUMULATE, 6, 32'h0002_0000, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_ACCUMULATE, -1, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_ACCUMULATE, 255, 32'h8000_0000, 1'b0, 32'h0000_0005, 1'b1, 1'b1,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 3, 32'h0, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 4, 32'h0, 1'b0, 32'h8000_0000, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 6, 32'h0, 1'b0, 32'h0001_0000, 1'b1, 1'b0,
                1'b1, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 255, 32'h0, 1'b0, 32'h0000_0001, 1'b1, 1'b0,
                1'b1, 32'h0, 1'b1);
        add_row(gwn_pkg::OP_APPLY, 3, 32'h0, 1'b0, 32'h0000_0000, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 4, 32'h0, 1'b0, 32'hFFFF_0000, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, -256, 32'h0, 1'b0, 32'h0001_0000, 1'b1, 1'b1,
                1'b1, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_ACCUMULATE, 1, 32'h0000_0005, 1'b1, 32'h0003_0000, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_ACCUMULATE, 2, 32'hFFFF_FFFB, 1'b1, 32'h0001_0000, 1'b1, 1'b0,
                1'b0, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 1, 32'h0, 1'b0, 32'h0001_0000, 1'b1, 1'b0,
                1'b1, 32'h0, 1'b0);
        add_row(gwn_pkg::OP_APPLY, 2, 32'h0, 1'b0, 32'h0002_0000, 1'b0, 1'b1,
                1'b1, 32'h0, 1'b0);
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
        end

        sent = 0;
        while (sent < 600)
        begin
            case (sent / 150)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    pressure = (sent > 40);
                end
                1:
                begin
                    idle_pct = 66;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 66;
                end
                default:
                begin
                    idle_pct = 16;
                    stall_pct = 16;
                end
            endcase
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
            begin
                r = rand_request(gwn_pkg::OP_ACCUMULATE, $urandom_range(0, 9) == 0);
                send_request(r, 1'b0, none);
                sent++;
            end
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
            begin
                r = rand_request(gwn_pkg::OP_APPLY, 1'b0);
                if (k == n - 1)
                begin
                    r.last = ($urandom_range(0, 9) != 0);
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    r.op = gwn_pkg::OP_ACCUMULATE;
                end
                send_request(r, 1'b0, none);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("group_weight_neutralizer_core test passed");
        end
        else
        begin
            $display("group_weight_neutralizer_core test failed");
        end
        $finish;
    end

endmodule
